@@ hdl/size_budget_fifo_cache_directory_assert.svh @@
`ifndef SIZE_BUDGET_FIFO_CACHE_DIRECTORY_ASSERT_SVH
`define SIZE_BUDGET_FIFO_CACHE_DIRECTORY_ASSERT_SVH

// same-cycle implication checked on every clock edge outside reset
`define SBFCD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define SBFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sbfcd_pkg.sv @@
package sbfcd_pkg;

   // default directory depth
   localparam int SBFCD_DEPTH = 16;

   localparam int KEY_W   = 64;
   localparam int SIZE_W  = 32;
   localparam int HNDL_W  = 32;
   localparam int BYTES_W = 40;

   // operation codes
   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_GET   = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   // csr register indexes
   localparam logic CSR_MAX_TOTAL  = 1'b0;
   localparam logic CSR_MAX_OBJECT = 1'b1;

   // stored directory entry
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
      logic [HNDL_W-1:0] handle;
   } entry_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISP,
      ST_SRD,
      ST_SCMP,
      ST_HIT,
      ST_CRD,
      ST_CWR,
      ST_EVCHK,
      ST_ERD,
      ST_EHIT,
      ST_RRD,
      ST_RPUSH,
      ST_NRD,
      ST_NLD,
      ST_NWAIT,
      ST_FWAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic cap;
      logic idx_top;
      logic idx_zero;
      logic idx_dec;
      logic idx_inc;
      logic rd_cur;
      logic rd_next;
      logic wr_shift;
      logic wr_append;
      logic push_notice;
      logic sub_bytes;
      logic take_got;
      logic cnt_dec;
      logic clear_all;
      logic fin_set;
      logic fin_ok;
      logic nq_rd;
      logic nq_pop;
      logic nq_clear;
      logic out_notice;
      logic out_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_set;
      logic op_get;
      logic op_reset;
      logic cnt_zero;
      logic idx_zero;
      logic key_match;
      logic next_in_range;
      logic idx_below_cnt;
      logic size_zero;
      logic size_over;
      logic need_evict;
      logic nq_more;
      logic rsp_pending;
      logic rsp_taken;
   } sts_type;

endpackage

@@ hdl/sbfcd_dpath.sv @@
module sbfcd_dpath import sbfcd_pkg::*; #(
   parameter int DEPTH = SBFCD_DEPTH,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [1:0]          req_opcode,
   input  logic [KEY_W-1:0]    req_entry_key,
   input  logic [SIZE_W-1:0]   req_entry_size,
   input  logic [HNDL_W-1:0]   req_entry_handle,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [BYTES_W-1:0]  csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_item_kind,
   output logic                rsp_op_ok,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [SIZE_W-1:0]   rsp_out_size,
   output logic [HNDL_W-1:0]   rsp_found_handle,
   output logic [CW-1:0]       rsp_entries_held,
   output logic [BYTES_W-1:0]  rsp_bytes_held,
   output logic                rsp_last_item
);

`include "size_budget_fifo_cache_directory_assert.svh"

   entry_type            ent_mem [DEPTH];
   entry_type            nq_mem  [DEPTH];

   logic [1:0]           op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [HNDL_W-1:0]    handle_ff;
   logic [CW-1:0]        cnt_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [CW-1:0]        idx_ff;
   logic [CW-1:0]        idx_in;
   entry_type            rd_ff;
   entry_type            nq_q_ff;
   logic [CW-1:0]        nq_wr_ff;
   logic [CW-1:0]        nq_rd_ff;
   logic [SIZE_W-1:0]    got_size_ff;
   logic [HNDL_W-1:0]    got_handle_ff;
   logic                 fin_ok_ff;
   logic [BYTES_W-1:0]   max_total_ff;
   logic [BYTES_W-1:0]   max_obj_ff;
   logic                 rsp_valid_ff;
   logic                 kind_ff;
   logic                 ok_ff;
   logic [KEY_W-1:0]     okey_ff;
   logic [SIZE_W-1:0]    osize_ff;
   logic [HNDL_W-1:0]    ohandle_ff;

   logic [BYTES_W-1:0]   limit;
   logic [BYTES_W:0]     bytes_sum;
   logic [CW-1:0]        idx_next;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;
   entry_type            new_ent;

   // limits and comparisons
   assign limit     = (max_obj_ff < max_total_ff) ? max_obj_ff : max_total_ff;
   assign bytes_sum = {1'b0, bytes_ff} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_ff};
   assign idx_next  = idx_ff + CW'(1);
   assign new_ent   = '{key: key_ff, size: size_ff, handle: handle_ff};

   always_comb begin
      sts.op_set        = (op_ff == OP_SET);
      sts.op_get        = (op_ff == OP_GET);
      sts.op_reset      = (op_ff == OP_RESET);
      sts.cnt_zero      = (cnt_ff == '0);
      sts.idx_zero      = (idx_ff == '0);
      sts.key_match     = (rd_ff.key == key_ff);
      sts.next_in_range = (idx_next < cnt_ff);
      sts.idx_below_cnt = (idx_ff < cnt_ff);
      sts.size_zero     = (size_ff == '0);
      sts.size_over     = ({{(BYTES_W - SIZE_W){1'b0}}, size_ff} > limit);
      sts.need_evict    = (cnt_ff != '0) &&
                          ((bytes_sum > {1'b0, max_total_ff}) || (cnt_ff == CW'(DEPTH)));
      sts.nq_more       = (nq_rd_ff < nq_wr_ff);
      sts.rsp_pending   = rsp_valid_ff;
      sts.rsp_taken     = rsp_valid_ff & rsp_ready;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= '1;
         max_obj_ff   <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_TOTAL:  max_total_ff <= csr_data;
            CSR_MAX_OBJECT: max_obj_ff   <= csr_data;
            default:        max_total_ff <= max_total_ff;
         endcase
      end
   end

   // captured request word
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         op_ff     <= req_opcode;
         key_ff    <= req_entry_key;
         size_ff   <= req_entry_size;
         handle_ff <= req_entry_handle;
      end
   end

   // walk index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_top) begin
         idx_in = cnt_ff - CW'(1);
      end else if (cmd.idx_zero) begin
         idx_in = '0;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - CW'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // entry count and byte total
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         bytes_ff <= '0;
      end else if (cmd.clear_all) begin
         cnt_ff   <= '0;
         bytes_ff <= '0;
      end else if (cmd.wr_append) begin
         cnt_ff   <= cnt_ff + CW'(1);
         bytes_ff <= bytes_sum[BYTES_W-1:0];
      end else begin
         if (cmd.cnt_dec) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (cmd.sub_bytes) begin
            bytes_ff <= bytes_ff - {{(BYTES_W - SIZE_W){1'b0}}, rd_ff.size};
         end
      end
   end

   // entry memory, one read and one write port
   assign rd_addr = cmd.rd_next ? idx_next[AW-1:0] : idx_ff[AW-1:0];
   assign wr_addr = cmd.wr_append ? cnt_ff[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data = cmd.wr_append ? new_ent : rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_shift || cmd.wr_append) begin
         ent_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_cur || cmd.rd_next) begin
         rd_ff <= ent_mem[rd_addr];
      end
   end

   // fetched entry of a get
   always_ff @(posedge clock) begin
      if (cmd.take_got) begin
         got_size_ff   <= rd_ff.size;
         got_handle_ff <= rd_ff.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ok_ff <= 1'b0;
      end else if (cmd.fin_set) begin
         fin_ok_ff <= cmd.fin_ok;
      end
   end

   // released-entry notice queue
   always_ff @(posedge clock) begin
      if (cmd.push_notice) begin
         nq_mem[nq_wr_ff[AW-1:0]] <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nq_rd) begin
         nq_q_ff <= nq_mem[nq_rd_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.nq_clear) begin
         nq_wr_ff <= '0;
         nq_rd_ff <= '0;
      end else begin
         if (cmd.push_notice) begin
            nq_wr_ff <= nq_wr_ff + CW'(1);
         end
         if (cmd.nq_pop) begin
            nq_rd_ff <= nq_rd_ff + CW'(1);
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_notice || cmd.out_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_notice) begin
         kind_ff    <= 1'b0;
         ok_ff      <= 1'b0;
         okey_ff    <= nq_q_ff.key;
         osize_ff   <= nq_q_ff.size;
         ohandle_ff <= nq_q_ff.handle;
      end else if (cmd.out_final) begin
         kind_ff    <= 1'b1;
         ok_ff      <= fin_ok_ff;
         okey_ff    <= (sts.op_set || sts.op_get) ? key_ff : '0;
         osize_ff   <= (sts.op_get && fin_ok_ff) ? got_size_ff : '0;
         ohandle_ff <= (sts.op_get && fin_ok_ff) ? got_handle_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item_kind    = kind_ff;
   assign rsp_op_ok        = ok_ff;
   assign rsp_out_key      = okey_ff;
   assign rsp_out_size     = osize_ff;
   assign rsp_found_handle = ohandle_ff;
   assign rsp_entries_held = cnt_ff;
   assign rsp_bytes_held   = bytes_ff;
   assign rsp_last_item    = kind_ff;

   `SBFCD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= CW'(DEPTH), "entry count above depth")
   `SBFCD_ASSERT_NOW(a_append_room, cmd.wr_append, cnt_ff < CW'(DEPTH), "append into full table")
   `SBFCD_ASSERT_NOW(a_nq_order, 1'b1, nq_rd_ff <= nq_wr_ff, "notice queue read past write")
   `SBFCD_ASSERT_NEXT(a_append_count, cmd.wr_append && !cmd.clear_all,
                      cnt_ff == $past(cnt_ff) + CW'(1), "append did not bump count")

endmodule

@@ hdl/sbfcd_ctrl.sv @@
module sbfcd_ctrl import sbfcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

`include "size_budget_fifo_cache_directory_assert.svh"

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            priority if (sts.op_set || sts.op_get) begin
               if (sts.cnt_zero) begin
                  if (sts.op_get) begin
                     cmd.fin_set = 1'b1;
                     state_in    = ST_NRD;
                  end else begin
                     state_in    = ST_EVCHK;
                  end
               end else begin
                  cmd.idx_top = 1'b1;
                  state_in    = ST_SRD;
               end
            end else if (sts.op_reset) begin
               cmd.idx_zero = 1'b1;
               state_in     = ST_RRD;
            end else begin
               // unknown opcode: refused, no state change
               cmd.fin_set = 1'b1;
               state_in    = ST_NRD;
            end
         end
         // search from newest entry
         ST_SRD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_SCMP;
         end
         ST_SCMP: begin
            priority if (sts.key_match) begin
               state_in = ST_HIT;
            end else if (sts.idx_zero) begin
               if (sts.op_get) begin
                  cmd.fin_set = 1'b1;
                  state_in    = ST_NRD;
               end else begin
                  state_in    = ST_EVCHK;
               end
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = ST_SRD;
            end
         end
         ST_HIT: begin
            cmd.sub_bytes = 1'b1;
            if (sts.op_get) begin
               cmd.take_got = 1'b1;
            end else begin
               cmd.push_notice = 1'b1;
            end
            state_in = ST_CRD;
         end
         // close the gap left by a removed entry
         ST_CRD: begin
            if (sts.next_in_range) begin
               cmd.rd_next = 1'b1;
               state_in    = ST_CWR;
            end else begin
               cmd.cnt_dec = 1'b1;
               if (sts.op_get) begin
                  cmd.fin_set = 1'b1;
                  cmd.fin_ok  = 1'b1;
                  state_in    = ST_NRD;
               end else begin
                  state_in    = ST_EVCHK;
               end
            end
         end
         ST_CWR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = ST_CRD;
         end
         // set: size checks, eviction of oldest, append
         ST_EVCHK: begin
            cmd.fin_set = 1'b1;
            priority if (sts.size_zero) begin
               cmd.fin_ok = 1'b1;
               state_in   = ST_NRD;
            end else if (sts.size_over) begin
               state_in   = ST_NRD;
            end else if (sts.need_evict) begin
               cmd.fin_set  = 1'b0;
               cmd.idx_zero = 1'b1;
               state_in     = ST_ERD;
            end else begin
               cmd.wr_append = 1'b1;
               cmd.fin_ok    = 1'b1;
               state_in      = ST_NRD;
            end
         end
         ST_ERD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_EHIT;
         end
         ST_EHIT: begin
            cmd.push_notice = 1'b1;
            cmd.sub_bytes   = 1'b1;
            state_in        = ST_CRD;
         end
         // reset all: release every entry oldest first
         ST_RRD: begin
            if (sts.idx_below_cnt) begin
               cmd.rd_cur = 1'b1;
               state_in   = ST_RPUSH;
            end else begin
               cmd.clear_all = 1'b1;
               cmd.fin_set   = 1'b1;
               cmd.fin_ok    = 1'b1;
               state_in      = ST_NRD;
            end
         end
         ST_RPUSH: begin
            cmd.push_notice = 1'b1;
            cmd.idx_inc     = 1'b1;
            state_in        = ST_RRD;
         end
         // emit notices, then the final word
         ST_NRD: begin
            if (sts.nq_more) begin
               cmd.nq_rd = 1'b1;
               state_in  = ST_NLD;
            end else begin
               cmd.out_final = 1'b1;
               state_in      = ST_FWAIT;
            end
         end
         ST_NLD: begin
            cmd.out_notice = 1'b1;
            state_in       = ST_NWAIT;
         end
         ST_NWAIT: begin
            if (sts.rsp_taken) begin
               cmd.nq_pop = 1'b1;
               state_in   = ST_NRD;
            end
         end
         ST_FWAIT: begin
            if (sts.rsp_taken) begin
               cmd.nq_clear = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SBFCD_ASSERT_NOW(a_idle_drained, state_ff == ST_IDLE, !sts.rsp_pending,
                     "idle with a word still pending")
   `SBFCD_ASSERT_NOW(a_get_no_notice, cmd.push_notice, !sts.op_get,
                     "get released a notice")
   `SBFCD_ASSERT_NEXT(a_final_last, cmd.out_final, state_ff == ST_FWAIT && sts.rsp_pending,
                      "final word not presented")

endmodule

@@ hdl/size_budget_fifo_cache_directory.sv @@
// FIFO key/value cache directory with a byte budget.
// Request channel (req_valid/req_ready): one word per operation, opcode set,
// get-and-take or reset-all, with key, size and handle.
// Response channel (rsp_valid/rsp_ready): one notice word per released entry,
// in the order released, then one final word with rsp_last_item high. Every word of an
// operation carries the entry count and byte total after the whole operation.
// csr_write/csr_index/csr_data set the total and per-object byte limits; write
// them only while the block is idle.
// Operations run one at a time. A search looks at entries newest first;
// removing an entry moves each younger entry down in turn, since the entry
// memory has one read and one write port. Each notice word is read from the
// notice queue, loaded into the output register and held until taken, and
// then the final word is presented, so any receiver stall lengthens the
// operation; each eviction of a set removes the oldest entry and moves the
// rest down.
// A stalled receiver holds the block in its output stage; req_ready stays low.
// Reset clears the count and byte total and sets the limits to all ones
// (unlimited); stored entries are not cleared and need no clearing pass.
module size_budget_fifo_cache_directory import sbfcd_pkg::*; #(
   parameter int DEPTH = SBFCD_DEPTH,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [KEY_W-1:0]   req_entry_key,
   input  logic [SIZE_W-1:0]  req_entry_size,
   input  logic [HNDL_W-1:0]  req_entry_handle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_item_kind,
   output logic               rsp_op_ok,
   output logic [KEY_W-1:0]   rsp_out_key,
   output logic [SIZE_W-1:0]  rsp_out_size,
   output logic [HNDL_W-1:0]  rsp_found_handle,
   output logic [CW-1:0]      rsp_entries_held,
   output logic [BYTES_W-1:0] rsp_bytes_held,
   output logic               rsp_last_item,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [BYTES_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   sbfcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, counters and output register
   sbfcd_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_entry_key    (req_entry_key),
      .req_entry_size   (req_entry_size),
      .req_entry_handle (req_entry_handle),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_op_ok        (rsp_op_ok),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_size     (rsp_out_size),
      .rsp_found_handle (rsp_found_handle),
      .rsp_entries_held (rsp_entries_held),
      .rsp_bytes_held   (rsp_bytes_held),
      .rsp_last_item    (rsp_last_item)
   );

endmodule

@@ dv/sbfcd_checker.sv @@
module sbfcd_checker import sbfcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [KEY_W-1:0]   req_entry_key,
   input  logic [SIZE_W-1:0]  req_entry_size,
   input  logic [HNDL_W-1:0]  req_entry_handle,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_item_kind,
   input  logic               rsp_op_ok,
   input  logic [KEY_W-1:0]   rsp_out_key,
   input  logic [SIZE_W-1:0]  rsp_out_size,
   input  logic [HNDL_W-1:0]  rsp_found_handle,
   input  logic [4:0]         rsp_entries_held,
   input  logic [BYTES_W-1:0] rsp_bytes_held,
   input  logic               rsp_last_item,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [BYTES_W-1:0] csr_data,
   output int                 fail_count,
   output int                 words_pending
);

   typedef struct packed {
      logic               kind;
      logic               ok;
      logic [KEY_W-1:0]   key;
      logic [SIZE_W-1:0]  size;
      logic [HNDL_W-1:0]  handle;
      logic [4:0]         held;
      logic [BYTES_W-1:0] bytes;
      logic               last;
   } word_type;

   entry_type          dir_q[$];
   logic [BYTES_W-1:0] bytes_total;
   logic [BYTES_W-1:0] total_limit;
   logic [BYTES_W-1:0] object_limit;
   word_type           expected_words[$];
   word_type           op_words[$];

   assign words_pending = expected_words.size();

   // release entry i as a notice word
   function automatic void release_entry(int i);
      word_type w;
      w = '0;
      w.key = dir_q[i].key;
      w.size = dir_q[i].size;
      w.handle = dir_q[i].handle;
      op_words.push_back(w);
      bytes_total -= dir_q[i].size;
      dir_q.delete(i);
   endfunction

   function automatic int find_newest(logic [KEY_W-1:0] k);
      for (int i = dir_q.size() - 1; i >= 0; i--)
         if (dir_q[i].key == k) return i;
      return -1;
   endfunction

   // apply one operation to the directory and queue its words
   function automatic void predict_op(logic [1:0] op, logic [KEY_W-1:0] k,
                                      logic [SIZE_W-1:0] sz, logic [HNDL_W-1:0] hd);
      word_type   fin;
      int         pos;
      logic [BYTES_W-1:0] lim;
      logic [BYTES_W:0]   sum;
      entry_type  e;
      fin = '0;
      fin.kind = 1'b1;
      fin.last = 1'b1;
      op_words.delete();
      case (op)
         OP_SET: begin
            lim = (object_limit < total_limit) ? object_limit : total_limit;
            pos = find_newest(k);
            if (pos >= 0) release_entry(pos);
            fin.key = k;
            if (sz == 0) fin.ok = 1'b1;
            else if (BYTES_W'(sz) > lim) fin.ok = 1'b0;
            else begin
               forever begin
                  sum = {1'b0, bytes_total} + sz;
                  if (dir_q.size() == 0) break;
                  if (sum <= {1'b0, total_limit} && dir_q.size() < SBFCD_DEPTH) break;
                  release_entry(0);
               end
               e.key = k;
               e.size = sz;
               e.handle = hd;
               dir_q.push_back(e);
               bytes_total += sz;
               fin.ok = 1'b1;
            end
         end
         OP_GET: begin
            pos = find_newest(k);
            fin.key = k;
            if (pos >= 0) begin
               fin.ok = 1'b1;
               fin.size = dir_q[pos].size;
               fin.handle = dir_q[pos].handle;
               bytes_total -= dir_q[pos].size;
               dir_q.delete(pos);
            end
         end
         OP_RESET: begin
            while (dir_q.size() > 0) release_entry(0);
            bytes_total = '0;
            fin.ok = 1'b1;
         end
         default: fin.ok = 1'b0;
      endcase
      op_words.push_back(fin);
      foreach (op_words[i]) begin
         op_words[i].held = 5'(dir_q.size());
         op_words[i].bytes = bytes_total;
         expected_words.push_back(op_words[i]);
      end
   endfunction

   task automatic report_mismatch(string what, logic [KEY_W-1:0] got,
                                  logic [KEY_W-1:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         dir_q.delete();
         expected_words.delete();
         bytes_total = '0;
         total_limit = '1;
         object_limit = '1;
         fail_count = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_MAX_TOTAL) total_limit = csr_data;
            else object_limit = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_out_key, '0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_item_kind !== w.kind) report_mismatch("item_kind", rsp_item_kind, w.kind);
               if (rsp_op_ok !== w.ok) report_mismatch("op_ok", rsp_op_ok, w.ok);
               if (rsp_out_key !== w.key) report_mismatch("out_key", rsp_out_key, w.key);
               if (rsp_out_size !== w.size) report_mismatch("out_size", rsp_out_size, w.size);
               if (rsp_found_handle !== w.handle)
                  report_mismatch("found_handle", rsp_found_handle, w.handle);
               if (rsp_entries_held !== w.held)
                  report_mismatch("entries_held", rsp_entries_held, w.held);
               if (rsp_bytes_held !== w.bytes)
                  report_mismatch("bytes_held", rsp_bytes_held, w.bytes);
               if (rsp_last_item !== w.last)
                  report_mismatch("last_item", rsp_last_item, w.last);
            end
         end
         if (req_valid && req_ready)
            predict_op(req_opcode, req_entry_key, req_entry_size, req_entry_handle);
      end
   end

endmodule

@@ dv/tb.sv @@
module tb;
   import sbfcd_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [KEY_W-1:0]   req_entry_key;
   logic [SIZE_W-1:0]  req_entry_size;
   logic [HNDL_W-1:0]  req_entry_handle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_item_kind;
   logic               rsp_op_ok;
   logic [KEY_W-1:0]   rsp_out_key;
   logic [SIZE_W-1:0]  rsp_out_size;
   logic [HNDL_W-1:0]  rsp_found_handle;
   logic [4:0]         rsp_entries_held;
   logic [BYTES_W-1:0] rsp_bytes_held;
   logic               rsp_last_item;
   logic               csr_write;
   logic               csr_index;
   logic [BYTES_W-1:0] csr_data;
   int                 fail_count;
   int                 words_pending;
   logic               calm;
   logic               hold_off;
   int                 idle_cycles;
   logic [KEY_W-1:0]   key_pool[8];

   size_budget_fifo_cache_directory uut (.*);

   sbfcd_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a hold-off stretch on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < 400; n++) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // valid stays high after acceptance; the next call replaces the word or a drain drops it
   task automatic send_op(logic [1:0] op, logic [KEY_W-1:0] k,
                          logic [SIZE_W-1:0] sz, logic [HNDL_W-1:0] hd);
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_key <= k;
      req_entry_size <= sz;
      req_entry_handle <= hd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_then_write(logic idx, logic [BYTES_W-1:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (800) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // one random operation, mostly set and get on a small key pool
   task automatic random_op(logic [SIZE_W-1:0] size_cap);
      int r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)];
      if (r < 55)
         send_op(OP_SET, k, ($urandom_range(15) == 0) ? 0 : $urandom_range(size_cap),
                 $urandom);
      else if (r < 90) send_op(OP_GET, k, $urandom, $urandom);
      else if (r < 96) send_op(OP_RESET, {$urandom, $urandom}, $urandom, $urandom);
      else send_op(2'd3, {$urandom, $urandom}, $urandom, $urandom);
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_SET;
      req_entry_key = '0;
      req_entry_size = '0;
      req_entry_handle = '0;
      csr_write = 1'b0;
      csr_index = CSR_MAX_TOTAL;
      csr_data = '0;
      calm = 1'b0;
      hold_off = 1'b0;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, full table, refusal, bad opcode
      send_op(OP_SET, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_SET, '1, 1, 0);
      send_op(OP_GET, '1, 0, 0);
      send_op(OP_GET, '1, 0, 0);
      send_op(OP_SET, '0, 0, 5);
      for (int i = 0; i < 18; i++) send_op(OP_SET, KEY_W'(i + 100), i + 1, i);
      send_op(2'd3, '1, '1, '1);
      send_op(OP_RESET, '0, 0, 0);

      // tight limits: refusal with same-key release and eviction by budget
      drain_then_write(CSR_MAX_TOTAL, 40'd100);
      drain_then_write(CSR_MAX_OBJECT, 40'd60);
      send_op(OP_SET, 64'd7, 50, 1);
      send_op(OP_SET, 64'd8, 40, 2);
      send_op(OP_SET, 64'd7, 61, 3);
      send_op(OP_SET, 64'd9, 60, 4);
      for (int i = 0; i < 70; i++) random_op(80);

      // lowered below what is held, then zero limits
      drain_then_write(CSR_MAX_TOTAL, 40'd30);
      for (int i = 0; i < 30; i++) random_op(40);
      drain_then_write(CSR_MAX_TOTAL, '0);
      drain_then_write(CSR_MAX_OBJECT, '0);
      for (int i = 0; i < 15; i++) random_op(3);

      // unlimited again: full table, long calm stretch and receiver hold-off
      drain_then_write(CSR_MAX_TOTAL, '1);
      drain_then_write(CSR_MAX_OBJECT, '1);
      calm = 1'b1;
      hold_off = 1'b1;
      for (int i = 0; i < 40; i++) random_op('1);
      calm = 1'b0;
      drain_then_write(CSR_MAX_TOTAL, 40'h1_0000_0000);
      drain_then_write(CSR_MAX_OBJECT, 40'hFF_FFFF_FFFF);
      for (int i = 0; i < 90; i++) random_op('1);

      req_valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (words_pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (800) @(posedge clock);
      if (fail_count == 0 && words_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ size_budget_fifo_cache_directory.f @@
+incdir+hdl
hdl/sbfcd_pkg.sv
hdl/sbfcd_dpath.sv
hdl/sbfcd_ctrl.sv
hdl/size_budget_fifo_cache_directory.sv
dv/sbfcd_checker.sv
dv/tb.sv
